[rtl/cdsr_pkg.sv]
// Shared types and constants for the class density ranking block.
// Depends on nothing; imported by every module of the block.
package cdsr_pkg;

	localparam int unsigned DEF_MAX_CLASSES = 16;
	localparam int unsigned DENS_W = 32;
	localparam int unsigned CLASS_W = 4;
	localparam int unsigned FRAC_W = 17;
	localparam int unsigned FRAC_SHIFT = 16;
	localparam int unsigned FACTOR_W = FRAC_W + 1;
	localparam int unsigned PROD_W = DENS_W + FACTOR_W;
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

	typedef struct packed {
		logic signed [DENS_W-1:0] density;
		logic [CLASS_W-1:0] class_id;
		logic is_set;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT,
		OP_CLEAR
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MULT,
		ST_EMIT
	} st_t;

endpackage

[rtl/cdsr_cell.sv]
// One cell of the sorted insertion chain: holds one ranked entry.
// Depends on cdsr_pkg for entry_t and cell_op_t.
module cdsr_cell
	import cdsr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  entry_t   new_e,
	input  entry_t   prev_e,
	input  logic     prev_valid,
	input  logic     prev_keep,
	input  entry_t   next_e,
	input  logic     next_valid,
	output entry_t   e,
	output logic     valid,
	output logic     keep
);

	entry_t e_q;
	logic   valid_q;

	// stay in place when strictly denser than the arriving entry
	assign keep  = valid_q && ($signed(e_q.density) > $signed(new_e.density));
	assign e     = e_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				OP_INSERT: begin
					if (!keep) valid_q <= prev_keep ? 1'b1 : prev_valid;
				end
				OP_SHIFT: valid_q <= next_valid;
				OP_CLEAR: valid_q <= 1'b0;
				default:  valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_INSERT: begin
				if (!keep) e_q <= prev_keep ? new_e : prev_e;
			end
			OP_SHIFT: e_q <= next_e;
			default:  e_q <= e_q;
		endcase
	end

endmodule

[rtl/class_density_sorted_rank.sv]
// Top level of the class density ranking block: cell chain, threshold, sequencer.
// Depends on cdsr_pkg and cdsr_cell.
//
// Usage:
//   Items enter on density/class_id/is_set/last, taken when start is high and
//   busy is low. Each item drops into a chain of MAX_CLASSES cells kept sorted
//   by descending density; a new item lands ahead of stored equal densities.
//   Items without last keep busy low, so one item per cycle streams in. An
//   item that finds the chain full is dropped and the overflow flag is raised.
//   On an item with last, busy rises: the ST_MULT state forms the threshold
//   product (one 18x32 multiply of the top density), then in ST_EMIT the chain
//   shifts toward cell 0 one entry per cycle, emitting each entry above the
//   threshold. The taken last item passes ST_MULT, then ST_EMIT loads the
//   registered result fields; results follow one per cycle, each marked by
//   strobe for exactly one cycle. end_of_list marks the final one.
//   If nothing passes, one result with none_selected comes out instead.
//   The chain and the overflow flag then clear and busy drops.
//   The receiver cannot stall; results are never held.
//   keep_fraction is written on cfg_valid/cfg_ready (always ready); the user
//   must write it only while idle, which the block itself leaves unenforced.
//   Reset empties the chain, clears overflow and sets keep_fraction to zero.
module class_density_sorted_rank
	import cdsr_pkg::*;
#(
	parameter int unsigned MAX_CLASSES = DEF_MAX_CLASSES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DENS_W-1:0] density,
	input  logic [CLASS_W-1:0]       class_id,
	input  logic                     is_set,
	input  logic                     last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [FRAC_W-1:0]        cfg_data,
	output logic                     strobe,
	output logic signed [DENS_W-1:0] sel_density,
	output logic [CLASS_W-1:0]       sel_class,
	output logic                     sel_is_set,
	output logic                     end_of_list,
	output logic                     none_selected,
	output logic                     overflowed
);

	localparam int unsigned NXT = (MAX_CLASSES > 1) ? 1 : 0;

	st_t state_q, state_d;
	logic [FRAC_W-1:0] keep_frac_q;
	logic overflow_q;
	logic signed [PROD_W-1:0] rhs_q;

	entry_t new_e;
	entry_t cell_e [MAX_CLASSES];
	logic [MAX_CLASSES-1:0] cell_valid;
	logic [MAX_CLASSES-1:0] cell_keep;
	cell_op_t cell_op;

	logic accept, full;
	logic pass0, pass1;
	logic load_out, out_none, out_end;
	logic signed [FACTOR_W-1:0] factor;
	logic signed [PROD_W-1:0] lhs0, lhs1;

	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign full = cell_valid[MAX_CLASSES-1];
	assign new_e = '{density: density, class_id: class_id, is_set: is_set};

	// build the chain; cell 0 has no left neighbor, the last cell no right one
	for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
		entry_t p_e, n_e;
		logic   p_v, p_k, n_v;
		if (i == 0) begin : g_first
			assign p_e = new_e;
			assign p_v = 1'b1;
			assign p_k = 1'b1;
		end else begin : g_mid
			assign p_e = cell_e[i-1];
			assign p_v = cell_valid[i-1];
			assign p_k = cell_keep[i-1];
		end
		if (i == MAX_CLASSES - 1) begin : g_tail
			assign n_e = new_e;
			assign n_v = 1'b0;
		end else begin : g_body
			assign n_e = cell_e[i+1];
			assign n_v = cell_valid[i+1];
		end
		cdsr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (cell_op),
			.new_e      (new_e),
			.prev_e     (p_e),
			.prev_valid (p_v),
			.prev_keep  (p_k),
			.next_e     (n_e),
			.next_valid (n_v),
			.e          (cell_e[i]),
			.valid      (cell_valid[i]),
			.keep       (cell_keep[i])
		);
	end

	// threshold: density * 2^16 > (1 - fraction) * top, exact
	assign factor = $signed({1'b0, FRAC_ONE}) - $signed({1'b0, keep_frac_q});
	assign lhs0 = PROD_W'($signed({cell_e[0].density, FRAC_SHIFT'(0)}));
	assign lhs1 = PROD_W'($signed({cell_e[NXT].density, FRAC_SHIFT'(0)}));
	assign pass0 = cell_valid[0] && (lhs0 > rhs_q);
	assign pass1 = (MAX_CLASSES > 1) && cell_valid[NXT] && (lhs1 > rhs_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && last) state_d = ST_MULT;
			ST_MULT: state_d = ST_EMIT;
			ST_EMIT: if (!pass0 || !pass1) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy     = 1'b0;
		cell_op  = OP_HOLD;
		load_out = 1'b0;
		out_none = 1'b0;
		out_end  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !full) cell_op = OP_INSERT;
			end
			ST_MULT: busy = 1'b1;
			ST_EMIT: begin
				busy     = 1'b1;
				load_out = 1'b1;
				out_none = !pass0;
				out_end  = !pass0 || !pass1;
				// drop the whole chain once the run ends
				cell_op  = out_end ? OP_CLEAR : OP_SHIFT;
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keep_frac_q <= '0;
			overflow_q  <= 1'b0;
			strobe      <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= load_out;
			if (cfg_valid && cfg_ready) keep_frac_q <= cfg_data;
			if (accept && full) overflow_q <= 1'b1;
			else if (load_out && out_end) overflow_q <= 1'b0;
		end
	end

	// hold the threshold product for the run; register the result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) rhs_q <= factor * $signed(cell_e[0].density);
		if (load_out) begin
			sel_density   <= out_none ? '0 : cell_e[0].density;
			sel_class     <= out_none ? '0 : cell_e[0].class_id;
			sel_is_set    <= out_none ? 1'b0 : cell_e[0].is_set;
			end_of_list   <= out_end;
			none_selected <= out_none;
			overflowed    <= overflow_q;
		end
	end

endmodule

[rtl/cdsr_checker.sv]
// Port-level checks for the class density ranking block, bound to its top.
// Depends on cdsr_pkg for field widths.
module cdsr_checker
	import cdsr_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     strobe,
	input logic signed [DENS_W-1:0] sel_density,
	input logic [CLASS_W-1:0]       sel_class,
	input logic                     sel_is_set,
	input logic                     end_of_list,
	input logic                     none_selected
);

	a_none_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && none_selected |-> end_of_list)
		else $error("empty selection not marked end of list");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && none_selected |-> sel_density == 0 && sel_class == 0 && !sel_is_set)
		else $error("empty selection carries nonzero fields");

	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !end_of_list |=> strobe)
		else $error("gap inside a result run");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !end_of_list |-> busy)
		else $error("idle while a result run continues");

	a_no_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("result right after an accepted item");

endmodule

bind class_density_sorted_rank cdsr_checker u_cdsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.sel_density   (sel_density),
	.sel_class     (sel_class),
	.sel_is_set    (sel_is_set),
	.end_of_list   (end_of_list),
	.none_selected (none_selected)
);

[test/cdsr_checker.sv]
`timescale 1ns / 1ps
// Checker for class_density_sorted_rank: keeps its own ranked list, predicts each
// selection run and compares every strobed result. Depends on cdsr_pkg.
module cdsr_scoreboard
	import cdsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [DENS_W-1:0] density,
	input  logic [CLASS_W-1:0]       class_id,
	input  logic                     is_set,
	input  logic                     last,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [FRAC_W-1:0]        cfg_data,
	input  logic                     strobe,
	input  logic signed [DENS_W-1:0] sel_density,
	input  logic [CLASS_W-1:0]       sel_class,
	input  logic                     sel_is_set,
	input  logic                     end_of_list,
	input  logic                     none_selected,
	input  logic                     overflowed,
	output int                       fail_count,
	output int                       pending
);

	localparam int unsigned DEPTH = DEF_MAX_CLASSES;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic signed [DENS_W-1:0] dens;
		logic [CLASS_W-1:0]       cls;
		logic                     is_set;
		logic                     eol;
		logic                     none;
		logic                     ovf;
	} pick_t;

	entry_t            ranked [DEPTH];
	int unsigned       rank_len;
	bit                ovf_seen;
	logic [FRAC_W-1:0] keep_frac;
	entry_t            arriving;
	pick_t             picks_due [$];

	// Place an entry ahead of any stored entry of equal density; drop it when full.
	function automatic void rank_insert(entry_t e);
		int unsigned pos;
		int unsigned i;
		pos = 0;
		if (rank_len >= DEPTH) begin
			ovf_seen = 1'b1;
			return;
		end
		while (pos < rank_len && $signed(ranked[pos].density) > $signed(e.density))
			pos++;
		for (i = rank_len; i > pos; i--)
			ranked[i] = ranked[i - 1];
		ranked[pos] = e;
		rank_len++;
	endfunction

	// Append one expected result behind those already waiting.
	function automatic void queue_pick(pick_t p);
		picks_due.insert(picks_due.size(), p);
	endfunction

	// Queue every entry strictly above (1 - keep) * top, then clear the list.
	function automatic void rank_select();
		longint      thresh;
		longint      scaled;
		pick_t       run [DEPTH];
		pick_t       p;
		int unsigned i;
		int unsigned n;
		n = 0;
		thresh = 0;
		if (rank_len > 0)
			thresh = (longint'(FRAC_ONE) - longint'(keep_frac))
				* longint'($signed(ranked[0].density));
		for (i = 0; i < rank_len; i++) begin
			scaled = longint'($signed(ranked[i].density)) * 65536;
			if (scaled <= thresh)
				break;
			p.dens = ranked[i].density;
			p.cls = ranked[i].class_id;
			p.is_set = ranked[i].is_set;
			p.eol = 1'b0;
			p.none = 1'b0;
			p.ovf = ovf_seen;
			run[n] = p;
			n++;
		end
		if (n == 0) begin
			p.dens = '0;
			p.cls = '0;
			p.is_set = 1'b0;
			p.eol = 1'b1;
			p.none = 1'b1;
			p.ovf = ovf_seen;
			queue_pick(p);
		end else begin
			run[n - 1].eol = 1'b1;
			for (i = 0; i < n; i++)
				queue_pick(run[i]);
		end
		rank_len = 0;
		ovf_seen = 1'b0;
	endfunction

	function automatic void check_pick();
		pick_t want;
		bit    bad;
		if (picks_due.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("unexpected result: dens=%0d cls=%0d set=%0b eol=%0b none=%0b ovf=%0b",
					sel_density, sel_class, sel_is_set, end_of_list, none_selected,
					overflowed);
			fail_count++;
			return;
		end
		want = picks_due.pop_front();
		bad = (sel_density !== want.dens) || (sel_class !== want.cls)
			|| (sel_is_set !== want.is_set) || (end_of_list !== want.eol)
			|| (none_selected !== want.none) || (overflowed !== want.ovf);
		if (bad) begin
			if (fail_count < REPORT_MAX) begin
				$display("mismatch: expected dens=%0d cls=%0d set=%0b eol=%0b none=%0b ovf=%0b",
					want.dens, want.cls, want.is_set, want.eol, want.none, want.ovf);
				$display("          actual   dens=%0d cls=%0d set=%0b eol=%0b none=%0b ovf=%0b",
					sel_density, sel_class, sel_is_set, end_of_list, none_selected,
					overflowed);
			end
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_len = 0;
			ovf_seen = 1'b0;
			keep_frac = '0;
			picks_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (strobe)
				check_pick();
			if (cfg_valid && cfg_ready)
				keep_frac = cfg_data;
			if (start && !busy) begin
				arriving.density = density;
				arriving.class_id = class_id;
				arriving.is_set = is_set;
				rank_insert(arriving);
				if (last)
					rank_select();
			end
			pending = picks_due.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for class_density_sorted_rank: drives entry sets and keep_fraction
// writes, and gives the verdict. Depends on cdsr_pkg, cdsr_scoreboard and the block.
module tb_top;
	import cdsr_pkg::*;

	// Extra wait in drain once no result is pending, before checking busy.
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int TIMEOUT_NS = 2_000_000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [DENS_W-1:0] density;
	logic [CLASS_W-1:0]       class_id;
	logic                     is_set;
	logic                     last;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [FRAC_W-1:0]        cfg_data;
	logic                     strobe;
	logic signed [DENS_W-1:0] sel_density;
	logic [CLASS_W-1:0]       sel_class;
	logic                     sel_is_set;
	logic                     end_of_list;
	logic                     none_selected;
	logic                     overflowed;

	int fail_count;
	int pending;
	int idle_pct;

	class_density_sorted_rank uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.density(density),
		.class_id(class_id),
		.is_set(is_set),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.sel_density(sel_density),
		.sel_class(sel_class),
		.sel_is_set(sel_is_set),
		.end_of_list(end_of_list),
		.none_selected(none_selected),
		.overflowed(overflowed)
	);

	cdsr_scoreboard chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.density(density),
		.class_id(class_id),
		.is_set(is_set),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.sel_density(sel_density),
		.sel_class(sel_class),
		.sel_is_set(sel_is_set),
		.end_of_list(end_of_list),
		.none_selected(none_selected),
		.overflowed(overflowed),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item and hold it until taken. Every task starts and ends just
	// after a rising edge. busy only moves at rising edges, so look at it on
	// the falling edge to know whether the next rising edge takes the item.
	task automatic send_item(input logic signed [DENS_W-1:0] d, input logic [CLASS_W-1:0] c,
			input logic s, input logic l);
		bit took;
		// Idle each cycle with the given odds before offering the item.
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		density <= d;
		class_id <= c;
		is_set <= s;
		last <= l;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	// Hold off the sender until every expected result is in and the block is idle.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Write keep_fraction; call only after drain.
	task automatic write_frac(input logic [FRAC_W-1:0] v);
		bit took;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
	endtask

	// Favor the extremes: zero selects nothing, one keeps every positive entry,
	// the all-ones value makes the factor negative.
	function automatic logic [FRAC_W-1:0] pick_frac();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FRAC_ONE;
			2: return '1;
			3: return FRAC_W'(32768);
			default: return FRAC_W'($urandom_range(0, 131071));
		endcase
	endfunction

	// Mode 0 spans the full range, mode 1 sits on a coarse grid so ties and
	// exact threshold hits are common, mode 2 clusters positive values.
	// Extremes are mixed into every mode.
	function automatic logic signed [DENS_W-1:0] pick_density(input int mode);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return '0;
				3: return -1;
				default: return 1;
			endcase
		end
		case (mode)
			0: return $urandom();
			1: return (int'($urandom_range(0, 16)) - 8) * 32768;
			default: return 32'sh0100_0000 + int'($urandom_range(0, 32'h3FFFF));
		endcase
	endfunction

	// Mostly short sets; now and then a full list, or one that overflows.
	function automatic int pick_set_size();
		case ($urandom_range(0, 11))
			0: return $urandom_range(DEF_MAX_CLASSES + 1, DEF_MAX_CLASSES + 3);
			1: return DEF_MAX_CLASSES;
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic run_set(input int n);
		int mode;
		int i;
		mode = $urandom_range(0, 2);
		for (i = 0; i < n; i++)
			send_item(pick_density(mode), CLASS_W'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)), i == n - 1);
	endtask

	initial begin
		int phase;
		int sent;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		density = '0;
		class_id = '0;
		is_set = 1'b0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		// Release reset away from the rising edge.
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keep_fraction is zero out of reset, so even the top entry fails.
		send_item(32'sh7FFF_FFFF, 4'd15, 1'b1, 1'b1);
		drain();

		// Fraction of one: three equal densities come out newest first;
		// a lone most-negative entry selects nothing.
		write_frac(FRAC_ONE);
		send_item(32'sh0001_0000, 4'd1, 1'b0, 1'b0);
		send_item(32'sh0001_0000, 4'd2, 1'b1, 1'b0);
		send_item(32'sh0001_0000, 4'd3, 1'b0, 1'b1);
		send_item(32'sh8000_0000, 4'd0, 1'b0, 1'b1);
		drain();

		// Fraction above one: the threshold goes negative, the deep negative
		// entry still falls just short of it.
		write_frac('1);
		send_item(32'sh8000_0001, 4'd7, 1'b1, 1'b0);
		send_item(32'sh7FFF_FFFF, 4'd9, 1'b1, 1'b0);
		send_item(32'shC000_0000, 4'd4, 1'b0, 1'b1);
		drain();

		// One entry past capacity: the last item itself is dropped, selection
		// still runs and every result flags the overflow.
		write_frac(FRAC_W'(32768));
		run_set(DEF_MAX_CLASSES + 1);
		drain();

		// Random sets: sender idles 22 percent, then 47, then not at all.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 22 : (phase == 1) ? 47 : 0;
			sent = 0;
			write_frac(pick_frac());
			while (sent < ITEMS_PER_PHASE) begin
				n = pick_set_size();
				run_set(n);
				sent += n;
				// Now and then stop for a new fraction between sets.
				if (sent < ITEMS_PER_PHASE && $urandom_range(0, 3) == 0) begin
					drain();
					write_frac(pick_frac());
				end
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/cdsr_pkg.sv
rtl/cdsr_cell.sv
rtl/class_density_sorted_rank.sv
rtl/cdsr_checker.sv
test/cdsr_checker.sv
test/tb_top.sv
